### design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### design/sfla_pkg.sv
`timescale 1ns / 1ps
package sfla_pkg;
    localparam int CLS_W = 5;

    typedef enum logic [2:0] {
        S_BUILD, S_IDLE, S_SCAN, S_WR_SPARE, S_WR_BEST, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ST_OK, ST_NOMEM, ST_BADFREE, ST_FULL
    } t_status;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_CLASS = 2'd1;
    localparam logic [1:0] REG_BYTES = 2'd2;

    typedef struct packed {
        logic [31:0] start;
        logic [16:0] len;
        logic        used;
        logic        valid;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic we;
    } t_bld_stat;
endpackage

### design/sfla_ifs.sv
`timescale 1ns / 1ps
interface sfla_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] request_size;
    logic [31:0] free_address;
    modport source (output valid, action, request_size, free_address, input ready);
    modport sink (input valid, action, request_size, free_address, output ready);
endinterface

interface sfla_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] block_address;
    logic [31:0] fragment_count;
    modport source (output valid, status, block_address, fragment_count, input ready);
    modport sink (input valid, status, block_address, fragment_count, output ready);
endinterface

interface sfla_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### design/sfla_table_mem.sv
`timescale 1ns / 1ps
module sfla_table_mem
    import sfla_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);
    t_entry mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/sfla_rebuild.sv
`timescale 1ns / 1ps
module sfla_rebuild
    import sfla_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int AW          = 10,
    parameter int MAX_CLASSES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_base,
    input  logic [3:0]    i_class_count,
    input  logic [16:0]   i_bytes,
    output t_bld_stat     o_stat,
    output logic [AW-1:0] o_widx,
    output t_entry        o_wdata
);
    logic             r_busy;
    logic [AW-1:0]    r_slot;
    logic [CLS_W-1:0] r_cls;
    logic [CLS_W-1:0] r_classes;
    logic [16:0]      r_rem;
    logic [16:0]      r_len;
    logic [31:0]      r_addr;
    logic [31:0]      r_cbase;
    logic             load;
    logic [CLS_W-1:0] shamt;

    assign load  = (r_rem == 17'd0) && (r_cls < r_classes);
    assign shamt = r_cls + CLS_W'(3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && !load && r_slot == AW'(DEPTH - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_slot  <= '0;
            r_cls   <= '0;
            r_rem   <= '0;
            r_cbase <= i_base;
            if ({1'b0, i_class_count} > CLS_W'(MAX_CLASSES)) begin
                r_classes <= CLS_W'(MAX_CLASSES);
            end else begin
                r_classes <= CLS_W'(i_class_count);
            end
        end else if (r_busy) begin
            if (load) begin
                r_rem   <= i_bytes >> shamt;
                r_len   <= 17'd1 << shamt;
                r_addr  <= r_cbase;
                r_cbase <= r_cbase + 32'(i_bytes);
                r_cls   <= r_cls + CLS_W'(1);
            end else begin
                r_slot <= r_slot + AW'(1);
                if (r_rem != 17'd0) begin
                    r_rem  <= r_rem - 17'd1;
                    r_addr <= r_addr + 32'(r_len);
                end
            end
        end
    end

    always_comb begin
        o_stat.busy = r_busy;
        o_stat.we   = r_busy && !load;
        o_widx      = r_slot;
        if (r_rem != 17'd0) begin
            o_wdata = '{start: r_addr, len: r_len, used: 1'b0, valid: 1'b1};
        end else begin
            o_wdata = '0;
        end
    end
endmodule

### design/segregated_free_list_allocator_core.sv
`timescale 1ns / 1ps
// segregated free list allocator
// channels: i_req takes allocate/free beats, o_res gives one result beat per
// request, i_cfg writes base address, class count and bytes per class
// (ready always high, index beyond the list ignored)
// every request scans the whole block table, one entry per cycle through the
// single read port of the table memory, but for a free of address zero, which
// is answered without a scan; a split writes the spare and the chosen entry,
// and a block taken whole or released writes the chosen entry alone
// reset and every config write to base, class count or bytes rebuild the
// table in one sweep; no request is taken meanwhile and the split counter
// restarts at zero
// the result sits in an output register; while the receiver stalls, the next
// request is accepted and scanned, and it waits before its result is stored
`include "assert_macros.svh"
module segregated_free_list_allocator_core
    import sfla_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_CLASSES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sfla_req_if.sink   i_req,
    sfla_res_if.source o_res,
    sfla_cfg_if.sink   i_cfg
);
    localparam int AW = $clog2(TABLE_DEPTH);

    t_state      r_state, n_state;
    logic [31:0] r_base;
    logic [3:0]  r_ccnt;
    logic [16:0] r_bpc;
    logic        r_build_req;
    logic        r_act;
    logic [15:0] r_req;
    logic [31:0] r_faddr;
    logic [AW:0] r_issue;
    logic        r_pend;
    logic [AW-1:0] r_pidx;
    logic        r_found;
    logic [AW-1:0] r_bidx;
    logic [16:0] r_blen;
    logic [31:0] r_bstart;
    logic        r_hspare;
    logic [AW-1:0] r_spare;
    logic [31:0] r_splits;
    t_status     r_rs;
    logic [31:0] r_ra;
    logic        r_ov;
    t_status     r_os;
    logic [31:0] r_oa;
    logic [31:0] r_of;

    t_bld_stat   bld;
    logic [AW-1:0] bld_idx;
    t_entry      bld_data;
    t_entry      rd;
    logic        top_we;
    logic [AW-1:0] top_widx;
    t_entry      top_wdata;
    logic        mem_we;
    logic [AW-1:0] mem_widx;
    t_entry      mem_wdata;
    logic [AW-1:0] rd_addr;
    logic        req_beat, cfg_beat, res_take;
    logic        scan_end, need_split, better, hit;

    assign req_beat = i_req.valid && i_req.ready;
    assign cfg_beat = i_cfg.valid && i_cfg.ready && i_cfg.index <= REG_BYTES;
    assign res_take = !r_ov || o_res.ready;
    assign scan_end = (r_issue == (AW + 1)'(TABLE_DEPTH)) && !r_pend;
    assign need_split = r_blen != {1'b0, r_req};
    assign better = !r_found || rd.len < r_blen ||
                    (rd.len == r_blen && rd.start < r_bstart);
    assign hit = rd.valid && rd.used && rd.start == r_faddr;

    sfla_rebuild #(.DEPTH(TABLE_DEPTH), .AW(AW), .MAX_CLASSES(MAX_CLASSES)) u_rebuild (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (r_build_req),
        .i_base        (r_base),
        .i_class_count (r_ccnt),
        .i_bytes       (r_bpc),
        .o_stat        (bld),
        .o_widx        (bld_idx),
        .o_wdata       (bld_data)
    );

    assign mem_we    = bld.we || top_we;
    assign mem_widx  = bld.we ? bld_idx : top_widx;
    assign mem_wdata = bld.we ? bld_data : top_wdata;

    sfla_table_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_widx),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_BUILD: begin
                if (!r_build_req && !bld.busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (req_beat) begin
                    if (i_req.action == ACT_FREE && i_req.free_address == 32'd0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    if (!r_found) n_state = S_DONE;
                    else if (r_act == ACT_FREE) n_state = S_WR_BEST;
                    else if (!need_split) n_state = S_WR_BEST;
                    else if (!r_hspare) n_state = S_DONE;
                    else n_state = S_WR_SPARE;
                end
            end
            S_WR_SPARE: n_state = S_WR_BEST;
            S_WR_BEST:  n_state = S_DONE;
            S_DONE: begin
                if (res_take) n_state = S_IDLE;
            end
            default: n_state = S_BUILD;
        endcase
        if (cfg_beat) n_state = S_BUILD;
    end

    always_comb begin
        i_req.ready = 1'b0;
        top_we      = 1'b0;
        top_widx    = r_bidx;
        top_wdata   = '{start: r_bstart, len: r_blen, used: 1'b0, valid: 1'b1};
        rd_addr     = r_issue[AW-1:0];
        case (r_state)
            S_IDLE: i_req.ready = !r_build_req;
            S_WR_SPARE: begin
                top_we    = 1'b1;
                top_widx  = r_spare;
                top_wdata = '{start: r_bstart + 32'(r_req), len: r_blen - 17'(r_req),
                              used: 1'b0, valid: 1'b1};
            end
            S_WR_BEST: begin
                top_we = 1'b1;
                if (r_act == ACT_ALLOC) begin
                    top_wdata = '{start: r_bstart, len: 17'(r_req), used: 1'b1,
                                  valid: 1'b1};
                end
            end
            default: top_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BUILD;
            r_build_req <= 1'b1;
            r_base      <= 32'd65536;
            r_ccnt      <= 4'd4;
            r_bpc       <= 17'd1024;
            r_splits    <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_build_req <= cfg_beat;
            if (cfg_beat) begin
                case (i_cfg.index)
                    REG_BASE:  r_base <= i_cfg.data;
                    REG_CLASS: r_ccnt <= i_cfg.data[3:0];
                    REG_BYTES: r_bpc  <= i_cfg.data[16:0];
                    default:   r_base <= r_base;
                endcase
            end
            if (r_build_req) begin
                r_splits <= '0;
            end else if (r_state == S_WR_SPARE) begin
                r_splits <= r_splits + 32'd1;
            end
            if (r_state == S_DONE && res_take) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && res_take) begin
            r_os <= r_rs;
            r_oa <= r_ra;
            r_of <= r_splits;
        end
        case (r_state)
            S_IDLE: begin
                r_act    <= i_req.action;
                r_req    <= i_req.request_size;
                r_faddr  <= i_req.free_address;
                r_issue  <= '0;
                r_pend   <= 1'b0;
                r_found  <= 1'b0;
                r_hspare <= 1'b0;
                r_rs     <= ST_OK;
                r_ra     <= '0;
            end
            S_SCAN: begin
                r_pend <= (r_issue != (AW + 1)'(TABLE_DEPTH));
                if (r_issue != (AW + 1)'(TABLE_DEPTH)) begin
                    r_issue <= r_issue + (AW + 1)'(1);
                    r_pidx  <= r_issue[AW-1:0];
                end
                if (r_pend) begin
                    if (r_act == ACT_ALLOC) begin
                        if (!rd.valid) begin
                            if (!r_hspare) begin
                                r_hspare <= 1'b1;
                                r_spare  <= r_pidx;
                            end
                        end else if (!rd.used && rd.len >= {1'b0, r_req} && better) begin
                            r_found  <= 1'b1;
                            r_bidx   <= r_pidx;
                            r_blen   <= rd.len;
                            r_bstart <= rd.start;
                        end
                    end else if (hit && !r_found) begin
                        r_found  <= 1'b1;
                        r_bidx   <= r_pidx;
                        r_blen   <= rd.len;
                        r_bstart <= rd.start;
                    end
                end
                if (scan_end) begin
                    if (!r_found) begin
                        r_rs <= (r_act == ACT_ALLOC) ? ST_NOMEM : ST_BADFREE;
                    end else if (r_act == ACT_ALLOC && need_split && !r_hspare) begin
                        r_rs <= ST_FULL;
                    end
                end
            end
            S_WR_BEST: begin
                if (r_act == ACT_ALLOC) r_ra <= r_bstart;
            end
            default: r_pend <= 1'b0;
        endcase
    end

    assign o_res.valid          = r_ov;
    assign o_res.status         = r_os;
    assign o_res.block_address  = r_oa;
    assign o_res.fragment_count = r_of;
    assign i_cfg.ready          = 1'b1;

    `ASSERT_IMP(a_no_req_in_build, i_clk, i_rst_n, r_state == S_BUILD, !i_req.ready,
        "request accepted during table rebuild")
    `ASSERT_IMP(a_top_we_state, i_clk, i_rst_n, top_we,
        r_state == S_WR_SPARE || r_state == S_WR_BEST, "table write outside write state")
    `ASSERT_IMP(a_no_write_clash, i_clk, i_rst_n, bld.we, !top_we,
        "rebuild and update write the table together")
    `ASSERT_NXT(a_cfg_rebuild, i_clk, i_rst_n, cfg_beat, r_build_req && r_state == S_BUILD,
        "config beat did not start a rebuild")
endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import sfla_pkg::*;

    localparam int DEPTH = 1024;
    localparam int CLASS_MAX = 8;
    localparam int SCAN_CYCLES = DEPTH + 80;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct {
        t_status     status;
        logic [31:0] addr;
        logic [31:0] frag;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sfla_req_if req_if ();
    sfla_res_if res_if ();
    sfla_cfg_if cfg_if ();

    segregated_free_list_allocator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // allocator shadow state
    logic [31:0] shadow_base;
    logic [3:0]  shadow_classes;
    logic [16:0] shadow_bytes;
    logic [31:0] blk_start [DEPTH];
    logic [16:0] blk_len [DEPTH];
    bit          blk_used [DEPTH];
    bit          blk_live [DEPTH];
    logic [31:0] split_count;

    t_result     pending_results[$];
    logic [31:0] held_blocks[$];
    int          mismatches = 0;
    longint      cycles = 0;
    bit          quiet = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void rebuild_shadow();
        int slot;
        int classes;
        logic [16:0] len;
        int count;
        logic [31:0] addr;
        slot = 0;
        split_count = '0;
        for (int i = 0; i < DEPTH; i++) begin
            blk_start[i] = '0;
            blk_len[i] = '0;
            blk_used[i] = 1'b0;
            blk_live[i] = 1'b0;
        end
        classes = (shadow_classes > CLASS_MAX) ? CLASS_MAX : int'(shadow_classes);
        for (int c = 0; c < classes; c++) begin
            len = 17'(1) << (c + 3);
            count = int'(shadow_bytes / len);
            addr = shadow_base + 32'(c) * 32'(shadow_bytes);
            for (int k = 0; k < count && slot < DEPTH; k++) begin
                blk_start[slot] = addr;
                blk_len[slot] = len;
                blk_live[slot] = 1'b1;
                slot++;
                addr = addr + 32'(len);
            end
        end
    endfunction

    function automatic t_result alloc_shadow(logic [15:0] size);
        t_result r;
        int best;
        int spare;
        bit found;
        bit have_spare;
        logic [16:0] want;
        r.status = ST_OK;
        r.addr = '0;
        best = 0;
        spare = 0;
        found = 1'b0;
        have_spare = 1'b0;
        want = {1'b0, size};
        for (int i = 0; i < DEPTH; i++) begin
            if (!blk_live[i]) begin
                if (!have_spare) begin
                    spare = i;
                    have_spare = 1'b1;
                end
            end else if (!blk_used[i] && blk_len[i] >= want) begin
                if (!found || blk_len[i] < blk_len[best] ||
                    (blk_len[i] == blk_len[best] && blk_start[i] < blk_start[best])) begin
                    best = i;
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            r.status = ST_NOMEM;
        end else if (blk_len[best] != want && !have_spare) begin
            r.status = ST_FULL;
        end else begin
            if (blk_len[best] != want) begin
                blk_start[spare] = blk_start[best] + 32'(want);
                blk_len[spare] = blk_len[best] - want;
                blk_used[spare] = 1'b0;
                blk_live[spare] = 1'b1;
                split_count = split_count + 1;
            end
            blk_len[best] = want;
            blk_used[best] = 1'b1;
            r.addr = blk_start[best];
        end
        r.frag = split_count;
        return r;
    endfunction

    function automatic t_result free_shadow(logic [31:0] addr);
        t_result r;
        r.status = ST_BADFREE;
        r.addr = '0;
        if (addr == '0) begin
            r.status = ST_OK;
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                if (r.status == ST_BADFREE && blk_live[i] && blk_used[i] &&
                    blk_start[i] == addr) begin
                    blk_used[i] = 1'b0;
                    r.status = ST_OK;
                end
            end
        end
        r.frag = split_count;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d addr %h frag %0d",
                             res_if.status, res_if.block_address, res_if.fragment_count);
            end else begin
                want = pending_results.pop_front();
                if (res_if.status !== want.status || res_if.block_address !== want.addr ||
                    res_if.fragment_count !== want.frag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
                                 want.status, want.addr, want.frag, res_if.status,
                                 res_if.block_address, res_if.fragment_count);
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= quiet || ($urandom_range(99) >= 33);
    end

    task automatic send_req(logic act, logic [15:0] size, logic [31:0] addr);
        int gap;
        t_result r;
        gap = 0;
        while (!quiet && $urandom_range(99) < 33)
            gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.action <= act;
        req_if.request_size <= size;
        req_if.free_address <= addr;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (act == ACT_ALLOC) begin
            r = alloc_shadow(size);
            if (r.status == ST_OK && r.addr != '0)
                held_blocks.push_back(r.addr);
        end else begin
            r = free_shadow(addr);
        end
        pending_results.push_back(r);
    endtask

    task automatic alloc(logic [15:0] size);
        send_req(ACT_ALLOC, size, $urandom());
    endtask

    task automatic release_block(logic [31:0] addr);
        send_req(ACT_FREE, 16'($urandom()), addr);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SCAN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_BASE: shadow_base = data;
            REG_CLASS: shadow_classes = data[3:0];
            REG_BYTES: shadow_bytes = data[16:0];
            default: ;
        endcase
        if (idx != REG_NONE)
            rebuild_shadow();
        held_blocks.delete();
    endtask

    task automatic setup(logic [31:0] base, logic [31:0] classes, logic [31:0] bytes);
        write_reg(REG_BASE, base);
        write_reg(REG_CLASS, classes);
        write_reg(REG_BYTES, bytes);
    endtask

    task automatic test_default_layout();
        logic [31:0] a;
        alloc(16'd8);
        alloc(16'd1);
        alloc(16'd64);
        alloc(16'd65);
        alloc(16'hFFFF);
        alloc(16'd0);
        alloc(16'd33);
        release_block(32'h0001_0000);
        release_block(32'h0001_0000);
        release_block(32'd0);
        release_block(32'hFFFF_FFFF);
        alloc(16'd5);
        a = 32'h0001_0000 + 32'd1024 * 3;
        release_block(a);
    endtask

    task automatic test_address_zero_and_wrap();
        setup(32'd0, 32'd1, 32'h0001_0010);
        alloc(16'd8);
        release_block(32'd0);
        alloc(16'd8);
        alloc(16'd8);
        setup(32'hFFFF_FFF8, 32'd2, 32'd16);
        alloc(16'd8);
        alloc(16'd8);
        alloc(16'd16);
        release_block(32'hFFFF_FFF8);
        alloc(16'd3);
    endtask

    task automatic test_class_extremes();
        setup(32'h8000_0000, 32'd0, 32'd1024);
        alloc(16'd1);
        write_reg(REG_CLASS, 32'hFFFF_FFFF);
        alloc(16'd1024);
        alloc(16'd1025);
        write_reg(REG_BYTES, 32'd8);
        alloc(16'd9);
        alloc(16'd8);
        write_reg(REG_NONE, $urandom());
        alloc(16'd8);
    endtask

    task automatic test_table_full();
        setup(32'h0000_1000, 32'd8, 32'h0001_0000);
        alloc(16'd3);
        alloc(16'd8);
        release_block(32'h0000_1000);
        alloc(16'd9);
        write_reg(REG_BYTES, 32'hFFFF_FFFF);
        alloc(16'd7);
    endtask

    task automatic random_phase(int count);
        int pick;
        logic [15:0] size;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                case ($urandom_range(9))
                    0: size = 16'($urandom());
                    1: size = 16'($urandom_range(200, 1100));
                    default: size = 16'($urandom_range(1, 80));
                endcase
                alloc(size);
            end else if (pick < 85 && held_blocks.size() != 0) begin
                pick = $urandom_range(held_blocks.size() - 1);
                release_block(held_blocks[pick]);
                held_blocks.delete(pick);
            end else if (pick < 92 && held_blocks.size() != 0) begin
                release_block(held_blocks[$urandom_range(held_blocks.size() - 1)]);
            end else begin
                release_block($urandom());
            end
            if (n == count / 2)
                drain();
        end
    endtask

    task automatic test_random();
        setup(32'h0002_0000, 32'd4, 32'd256);
        random_phase(100);
        quiet = 1'b1;
        setup($urandom(), 32'd3, 32'd128);
        random_phase(60);
        quiet = 1'b0;
        setup(32'h00FF_0000, 32'd8, 32'd512);
        random_phase(120);
        setup(32'hFFFF_FF00, 32'd2, 32'd160);
        random_phase(120);
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.action = ACT_ALLOC;
        req_if.request_size = '0;
        req_if.free_address = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_BASE;
        cfg_if.data = '0;
        shadow_base = 32'h0001_0000;
        shadow_classes = 4'd4;
        shadow_bytes = 17'd1024;
        rebuild_shadow();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_layout();
        test_address_zero_and_wrap();
        test_class_extremes();
        test_table_full();
        test_random();
        drain();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
